[src/mks_pkg.sv]
`timescale 1ns / 1ps

package mks_pkg;

	localparam logic [7:0] CHAR_OPEN  = 8'h3c;
	localparam logic [7:0] CHAR_CLOSE = 8'h3e;
	localparam logic [7:0] CHAR_END   = 8'h00;

	localparam logic [2:0] WORD_GAP_LONG  = 3'd5;
	localparam logic [2:0] WORD_GAP_SHORT = 3'd2;
	localparam logic [2:0] CHAR_GAP       = 3'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		EV_DOT  = 2'd0,
		EV_DASH = 2'd1,
		EV_GAP  = 2'd2
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MARK,
		ST_SPACE,
		ST_TAIL
	} back_state_t;

	typedef struct packed {
		logic [3:0] elem_cnt;
		logic [7:0] dash;
		logic [2:0] tail_gaps;
	} cmd_t;

endpackage

[src/mks_front.sv]
`timescale 1ns / 1ps

module mks_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    char_byte,
	input  logic [15:0]   element_word,
	input  logic          q_full,
	output logic          cmd_push,
	output mks_pkg::cmd_t cmd
);

	logic [7:0] depth_q;
	logic       after_space_q;
	logic [7:0] depth_d;
	logic       after_space_d;
	logic [3:0] elem_cnt;
	logic [2:0] word_gaps;
	logic       accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	// count leading presence bits
	always_comb begin
		logic run;
		run      = 1'b1;
		elem_cnt = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (run && element_word[15 - i]) begin
				elem_cnt = elem_cnt + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
	end

	always_comb begin
		depth_d       = depth_q;
		after_space_d = after_space_q;
		word_gaps     = 3'd0;
		if (char_byte == mks_pkg::CHAR_OPEN) begin
			depth_d = depth_q + 8'd1;
		end else if (char_byte == mks_pkg::CHAR_CLOSE) begin
			if (depth_q != 8'd0) begin
				depth_d = depth_q - 8'd1;
			end
		end else if (element_word[15:8] != 8'd0) begin
			after_space_d = 1'b0;
		end else if (depth_q == 8'd0) begin
			word_gaps     = after_space_q ? mks_pkg::WORD_GAP_LONG : mks_pkg::WORD_GAP_SHORT;
			after_space_d = 1'b1;
		end
	end

	always_comb begin
		cmd.elem_cnt  = ((char_byte == mks_pkg::CHAR_OPEN) || (char_byte == mks_pkg::CHAR_CLOSE))
			? 4'd0 : elem_cnt;
		cmd.dash      = element_word[7:0];
		cmd.tail_gaps = word_gaps + ((depth_d == 8'd0) ? mks_pkg::CHAR_GAP : 3'd0);
		cmd_push      = accept && ((cmd.elem_cnt != 4'd0) || (cmd.tail_gaps != 3'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q       <= 8'd0;
			after_space_q <= 1'b1;
		end else if (accept) begin
			if (char_byte == mks_pkg::CHAR_END) begin
				depth_q       <= 8'd0;
				after_space_q <= 1'b1;
			end else begin
				depth_q       <= depth_d;
				after_space_q <= after_space_d;
			end
		end
	end

endmodule

[src/mks_cmd_queue.sv]
`timescale 1ns / 1ps

module mks_cmd_queue #(
	parameter int DEPTH = mks_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  mks_pkg::cmd_t wr_data,
	output logic          full,
	output logic          rd_valid,
	input  logic          rd_en,
	output mks_pkg::cmd_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mks_pkg::cmd_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entries_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/mks_back.sv]
`timescale 1ns / 1ps

module mks_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mks_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output logic [1:0]    event_kind,
	output logic          last_event
);

	mks_pkg::back_state_t state_q;
	mks_pkg::back_state_t state_d;
	logic [3:0]           el_q;
	logic [3:0]           el_d;
	logic [7:0]           dash_q;
	logic [7:0]           dash_d;
	logic [2:0]           tail_q;
	logic [2:0]           tail_d;
	logic                 out_valid_q;
	mks_pkg::event_kind_t out_kind_q;
	logic                 out_last_q;
	logic                 adv;
	logic                 emit;
	mks_pkg::event_kind_t emit_kind;
	logic                 emit_last;

	assign adv        = !out_valid_q || pop;
	assign empty      = !out_valid_q;
	assign event_kind = out_kind_q;
	assign last_event = out_last_q;

	always_comb begin
		state_d   = state_q;
		el_d      = el_q;
		dash_d    = dash_q;
		tail_d    = tail_q;
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		emit_kind = mks_pkg::EV_GAP;
		emit_last = 1'b0;
		case (state_q)
			mks_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					el_d    = cmd.elem_cnt;
					dash_d  = cmd.dash;
					tail_d  = cmd.tail_gaps;
					state_d = (cmd.elem_cnt != 4'd0) ? mks_pkg::ST_MARK : mks_pkg::ST_TAIL;
				end
			end
			mks_pkg::ST_MARK: begin
				if (adv) begin
					emit      = 1'b1;
					emit_kind = dash_q[7] ? mks_pkg::EV_DASH : mks_pkg::EV_DOT;
					state_d   = mks_pkg::ST_SPACE;
				end
			end
			mks_pkg::ST_SPACE: begin
				if (adv) begin
					emit      = 1'b1;
					emit_last = (el_q == 4'd1) && (tail_q == 3'd0);
					el_d      = el_q - 4'd1;
					dash_d    = {dash_q[6:0], 1'b0};
					if (el_q != 4'd1) begin
						state_d = mks_pkg::ST_MARK;
					end else if (tail_q != 3'd0) begin
						state_d = mks_pkg::ST_TAIL;
					end else begin
						state_d = mks_pkg::ST_IDLE;
					end
				end
			end
			mks_pkg::ST_TAIL: begin
				if (adv) begin
					emit      = 1'b1;
					emit_last = (tail_q == 3'd1);
					tail_d    = tail_q - 3'd1;
					if (tail_q == 3'd1) begin
						state_d = mks_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = mks_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mks_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		el_q   <= el_d;
		dash_q <= dash_d;
		tail_q <= tail_d;
		if (emit) begin
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
		end
	end

endmodule

[src/morse_keying_sequencer_top.sv]
`timescale 1ns / 1ps
// An accepted item is written to the command queue and loaded by the back sequencer; its first
// event is then registered on the result ports. Events come one per cycle while the result is
//   popped or empty; the back sequencer loads each item's command from the queue only after all
//   events of the item before have been emitted. Items that produce no events never reach it.
// Reset (arst_n low, asynchronous): bracket depth 0, after-space flag set, command queue empty.

module morse_keying_sequencer_top #(
	parameter int QUEUE_DEPTH = mks_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic [15:0] element_word,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_kind,
	output logic        last_event
);

	mks_pkg::cmd_t wr_cmd;
	mks_pkg::cmd_t rd_cmd;
	logic          cmd_push;
	logic          q_full;
	logic          cmd_valid;
	logic          cmd_pop;

	mks_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_byte    (char_byte),
		.element_word (element_word),
		.q_full       (q_full),
		.cmd_push     (cmd_push),
		.cmd          (wr_cmd)
	);

	mks_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (wr_cmd),
		.full     (q_full),
		.rd_valid (cmd_valid),
		.rd_en    (cmd_pop),
		.rd_data  (rd_cmd)
	);

	mks_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (rd_cmd),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.event_kind (event_kind),
		.last_event (last_event)
	);

endmodule

[src/mks_checker.sv]
`timescale 1ns / 1ps

module mks_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] event_kind,
	input logic       last_event
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(last_event)))
		else $error("result changed while waiting");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (event_kind != 2'd3))
		else $error("invalid event kind");

	a_mark_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_kind != mks_pkg::EV_GAP)) |-> !last_event)
		else $error("mark ended a transaction run");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> empty)
		else $error("result shown during reset");

endmodule

bind morse_keying_sequencer_top mks_checker u_mks_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.event_kind (event_kind),
	.last_event (last_event)
);
